// ===== rtl/core/lmt_pkg.sv =====
// ============================================================================
// lmt_pkg - shared types and constants for the LCD mode timing block
// Word formats, configuration indexes and reset values, mode codes and the
// saturating accumulator add used by the step logic.
// ============================================================================
package lmt_pkg;

    // Display modes, encoded as on the status register
    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } mode_t;

    // Mode mask applied when the display is switched off
    localparam logic [7:0] MODE_OFF_MASK = 8'hFC;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HBLANK_CYCLES    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_CYCLES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSFER_CYCLES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_PERIOD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_PERIOD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLANK_LINE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_LINE        = 3'd6;

    // Configuration reset values
    localparam logic [9:0]  RST_HBLANK_CYCLES    = 10'd204;
    localparam logic [9:0]  RST_SEARCH_CYCLES    = 10'd80;
    localparam logic [9:0]  RST_TRANSFER_CYCLES  = 10'd172;
    localparam logic [11:0] RST_LINE_PERIOD      = 12'd456;
    localparam logic [15:0] RST_VBLANK_PERIOD    = 16'd4560;
    localparam logic [7:0]  RST_FIRST_BLANK_LINE = 8'd144;
    localparam logic [7:0]  RST_LAST_LINE        = 8'd153;

    // Input word
    typedef struct packed {
        logic [7:0] cycles;
        logic       lcd_on;
        logic [7:0] line_compare;
        logic       hblank_irq_en;
        logic       vblank_irq_en;
        logic       search_irq_en;
        logic       match_irq_en;
    } in_item_t;

    // Result word
    typedef struct packed {
        logic [7:0] line;
        logic [1:0] lcd_mode;
        logic       coincident;
        logic       vblank_request;
        logic       status_request;
        logic       draw_line;
    } out_item_t;

    // Timing configuration
    typedef struct packed {
        logic [9:0]  hblank_cycles;
        logic [9:0]  search_cycles;
        logic [9:0]  transfer_cycles;
        logic [11:0] line_period;
        logic [15:0] vblank_period;
        logic [7:0]  first_blank_line;
        logic [7:0]  last_line;
    } cfg_t;

    // Timing state carried from word to word
    typedef struct packed {
        mode_t       mode;
        logic [15:0] cycle_acc;
        logic [15:0] blank_line_acc;
        logic [7:0]  line;
        logic        match_flag;
    } state_t;

    // 16-bit accumulate, clamped at all ones
    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [7:0] b);
        logic [16:0] sum;
        sum = {1'b0, a} + {9'd0, b};
        return sum[16] ? 16'hFFFF : sum[15:0];
    endfunction

endpackage

// ===== rtl/core/lmt_if.sv =====
// ============================================================================
// lmt_in_if / lmt_out_if - valid/ready channels of the LCD mode timing block
// One interface per direction, each with a source and a sink modport.
// ============================================================================
interface lmt_in_if;
    logic               valid;
    logic               ready;
    lmt_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface lmt_out_if;
    logic               valid;
    logic               ready;
    lmt_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/lcd_mode_timing_fsm.sv =====
// ============================================================================
// lcd_mode_timing_fsm - display mode timing machine
// Tracks search / transfer / hblank / vblank timing per CPU tick batch and
// returns line, mode, coincidence, interrupt requests and a draw strobe.
// ============================================================================
//
//  channel   dir  handshake           word
//  --------  ---  ------------------  ----------------------------------------
//  in_ch     in   valid/ready         cycles, lcd_on, line_compare, irq enables
//  out_ch    out  valid/ready         line, lcd_mode, coincident, requests, draw
//  cfg       in   cfg_we, no stall    cfg_index (0..6), cfg_data (16 bit)
//
//  One word per clock sustained while out_ch takes results. Path: input
//  register, then the step logic into the result register, which also commits
//  the timing state. A stalled result holds the input register; ready drops
//  only when both registers are full and out_ch is not taken. Asynchronous
//  active-low reset empties both registers and loads the timing state and
//  configuration with their reset values.
//
module lcd_mode_timing_fsm (
    input  logic                            clk,
    input  logic                            rst_n,
    lmt_in_if.sink                          in_ch,
    lmt_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [lmt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lmt_pkg::*;

    cfg_t      cfg;
    logic      s1_valid_reg;
    in_item_t  s1_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    state_t    state_reg;
    state_t    state_next;
    out_item_t res_next;
    logic      advance;
    logic      in_take;

    // Configuration registers
    lmt_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Step logic between the input register and the result register
    lmt_step u_step (
        .st      (state_reg),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Handshake
    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || !out_valid_reg || out_ch.ready;
    assign in_take     = in_ch.valid && in_ch.ready;

    // Control and timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg             <= 1'b0;
            out_valid_reg            <= 1'b0;
            state_reg.mode           <= MODE_SEARCH;
            state_reg.cycle_acc      <= 16'd0;
            state_reg.blank_line_acc <= 16'd0;
            state_reg.line           <= 8'd0;
            state_reg.match_flag     <= 1'b0;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;

            if (advance)
                state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_item_reg <= in_ch.payload;
        if (advance)
            out_item_reg <= res_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_item_reg;

endmodule

// ===== rtl/core/lmt_cfg_regs.sv =====
// ============================================================================
// lmt_cfg_regs - timing configuration registers
// Write-only register file; each write is masked to the register width.
// ============================================================================
module lmt_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lmt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lmt_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lmt_pkg::cfg_t                   cfg
);
    import lmt_pkg::*;

    cfg_t cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hblank_cycles    <= RST_HBLANK_CYCLES;
            cfg_reg.search_cycles    <= RST_SEARCH_CYCLES;
            cfg_reg.transfer_cycles  <= RST_TRANSFER_CYCLES;
            cfg_reg.line_period      <= RST_LINE_PERIOD;
            cfg_reg.vblank_period    <= RST_VBLANK_PERIOD;
            cfg_reg.first_blank_line <= RST_FIRST_BLANK_LINE;
            cfg_reg.last_line        <= RST_LAST_LINE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HBLANK_CYCLES:    cfg_reg.hblank_cycles    <= cfg_data[9:0];
                CFG_SEARCH_CYCLES:    cfg_reg.search_cycles    <= cfg_data[9:0];
                CFG_TRANSFER_CYCLES:  cfg_reg.transfer_cycles  <= cfg_data[9:0];
                CFG_LINE_PERIOD:      cfg_reg.line_period      <= cfg_data[11:0];
                CFG_VBLANK_PERIOD:    cfg_reg.vblank_period    <= cfg_data[15:0];
                CFG_FIRST_BLANK_LINE: cfg_reg.first_blank_line <= cfg_data[7:0];
                CFG_LAST_LINE:        cfg_reg.last_line        <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/lmt_step.sv =====
// ============================================================================
// lmt_step - one timing step of the display mode machine
// Combinational: accumulate the elapsed cycles, make at most one mode
// transition, and form the result word.
// ============================================================================
module lmt_step (
    input  lmt_pkg::state_t    st,
    input  lmt_pkg::in_item_t  item,
    input  lmt_pkg::cfg_t      cfg,
    output lmt_pkg::state_t    st_next,
    output lmt_pkg::out_item_t res
);
    import lmt_pkg::*;

    logic [15:0] acc_sum;
    logic [15:0] bl_sum;
    logic [7:0]  line_inc;
    logic [7:0]  vb_line;
    logic        vreq;
    logic        sreq;
    logic        draw;

    // Next state and interrupt requests
    always_comb
    begin
        acc_sum  = sat_add16(st.cycle_acc, item.cycles);
        bl_sum   = sat_add16(st.blank_line_acc, item.cycles);
        line_inc = st.line + 8'd1;
        vb_line  = (st.line < cfg.last_line) ? line_inc : st.line;
        st_next  = st;
        vreq     = 1'b0;
        sreq     = 1'b0;
        draw     = 1'b0;

        if (!item.lcd_on)
        begin
            // display off: counters and line cleared, match flag kept
            st_next.cycle_acc      = 16'd0;
            st_next.blank_line_acc = 16'd0;
            st_next.line           = 8'd0;
            st_next.mode           = mode_t'(st.mode & MODE_OFF_MASK[1:0]);
        end
        else
        begin
            st_next.cycle_acc = acc_sum;
            case (st.mode)
                MODE_HBLANK:
                begin
                    if (acc_sum >= {6'd0, cfg.hblank_cycles})
                    begin
                        st_next.cycle_acc  = acc_sum - {6'd0, cfg.hblank_cycles};
                        st_next.line       = line_inc;
                        st_next.match_flag = (line_inc == item.line_compare);
                        if ((line_inc == item.line_compare) && item.match_irq_en)
                            sreq = 1'b1;
                        if (line_inc == cfg.first_blank_line)
                        begin
                            st_next.mode = MODE_VBLANK;
                            vreq         = 1'b1;
                            if (item.vblank_irq_en)
                                sreq = 1'b1;
                        end
                        else
                        begin
                            st_next.mode = MODE_SEARCH;
                            if (item.search_irq_en)
                                sreq = 1'b1;
                        end
                    end
                end
                MODE_VBLANK:
                begin
                    st_next.blank_line_acc = bl_sum;
                    // per-line step, evaluated before the end of blank
                    if (bl_sum >= {4'd0, cfg.line_period})
                    begin
                        st_next.blank_line_acc = 16'd0;
                        st_next.line           = vb_line;
                        st_next.match_flag     = (vb_line == item.line_compare);
                        if ((vb_line == item.line_compare) && item.match_irq_en)
                            sreq = 1'b1;
                    end
                    // end of vertical blank: back to line zero
                    if (acc_sum >= cfg.vblank_period)
                    begin
                        st_next.blank_line_acc = 16'd0;
                        st_next.cycle_acc      = 16'd0;
                        st_next.line           = 8'd0;
                        st_next.match_flag     = (item.line_compare == 8'd0);
                        if ((item.line_compare == 8'd0) && item.match_irq_en)
                            sreq = 1'b1;
                        st_next.mode = MODE_SEARCH;
                        if (item.search_irq_en)
                            sreq = 1'b1;
                    end
                end
                MODE_SEARCH:
                begin
                    if (acc_sum >= {6'd0, cfg.search_cycles})
                    begin
                        st_next.cycle_acc = acc_sum - {6'd0, cfg.search_cycles};
                        st_next.mode      = MODE_TRANSFER;
                    end
                end
                MODE_TRANSFER:
                begin
                    if (acc_sum >= {6'd0, cfg.transfer_cycles})
                    begin
                        st_next.cycle_acc = acc_sum - {6'd0, cfg.transfer_cycles};
                        st_next.mode      = MODE_HBLANK;
                        draw              = 1'b1;
                        if (item.hblank_irq_en)
                            sreq = 1'b1;
                    end
                end
                default:
                begin
                    st_next = st;
                end
            endcase
        end
    end

    // Result word
    always_comb
    begin
        res.line           = st_next.line;
        res.lcd_mode       = st_next.mode;
        res.coincident     = st_next.match_flag;
        res.vblank_request = vreq;
        res.status_request = sreq;
        res.draw_line      = draw;
    end

endmodule

// ===== rtl/core/lmt_checker.sv =====
// ============================================================================
// lmt_checker - port-level assertions for lcd_mode_timing_fsm
// Watches the channel handshakes of the top level; attached by bind.
// ============================================================================
module lmt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input lmt_pkg::out_item_t out_word
);
    import lmt_pkg::*;

    // A result waiting on the sink stays up with the same word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word dropped or changed while stalled");

    // Result valid only goes low after the word was taken
    a_out_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(out_ready))
        else $error("result valid fell without a handshake");

    // Input backpressure only while the result register is stalled
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled with the output side free");

    // A fresh result needs an accepted word, passed through the input register
    a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result appeared without an accepted word");

endmodule

bind lcd_mode_timing_fsm lmt_checker u_lmt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (out_ch.payload)
);
